>>> hdl/substring_search_engine_defines.svh
// assertion macros shared by the substring search engine
`ifndef SUBSTRING_SEARCH_ENGINE_DEFINES_SVH
`define SUBSTRING_SEARCH_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sse_pkg.sv
// types, register codes and helpers of the substring search engine
package sse_pkg;

  localparam int NEEDLE_BYTES = 16;
  localparam int NIDX_W       = 4;
  localparam int LEN_W        = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int POS_W        = 32;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_CASE_FOLD      = 3'd3,
    REG_SEARCH_LIMIT   = 3'd4
  } cfg_reg_t;

  typedef logic [NEEDLE_BYTES-1:0][7:0] needle_t;

  // settings the comparator needs
  typedef struct packed {
    needle_t          needle;
    logic [LEN_W-1:0] used_len;
    logic             fold;
  } cmp_cfg_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) r = c + CASE_OFFSET;
    return r;
  endfunction

endpackage

>>> hdl/sse_match.sv
// parallel compare of the byte window against the needle
module sse_match
  import sse_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  cmp_cfg_t   cfg,
  input  logic [7:0] win [MAX_PATTERN],
  output logic       match
);

  // window byte i (newest at 0) lines up with needle byte used_len-1-i
  always_comb begin
    logic [LEN_W-1:0] nidx;
    logic [7:0]       nb;
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      nidx = cfg.used_len - LEN_W'(i + 1);
      nb   = cfg.needle[nidx[NIDX_W-1:0]];
      if (LEN_W'(i) < cfg.used_len) begin
        if (nb == 8'd0 || fold_char(win[i], cfg.fold) != fold_char(nb, cfg.fold)) begin
          match = 1'b0;
        end
      end
    end
  end

endmodule

>>> hdl/substring_search_engine.sv
// top level of the streaming substring search engine
//
// usage:
//   - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the needle
//     bytes, needle length, case folding and search limit; cfg_ready is always
//     high; writes must go in only while the block is idle, which it does not enforce
//   - in channel carries one haystack byte per item plus the last-byte mark;
//     a zero byte or the mark ends the string and rearms the search
//   - out channel gives at most one item per string: found with the start
//     offset of the first match, or not found with offset 0
//   - path: an accepted item is held in the input register, then decided into
//     the result register
//   - throughput: one item per cycle unless a result waits on out_ready; the byte
//     window is compared with the needle in one pass of parallel byte comparators
//   - stall: a result waiting on out_ready holds the input register; in_ready
//     stays high only while that register is empty, so one more item can be
//     taken in and then in_ready drops until the result is drained
//   - reset (rst_n low, synchronous): both stages empty, window and byte
//     counter clear, needle empty, folding off, search limit all ones
module substring_search_engine
  import sse_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // haystack items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_last_byte,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [POS_W-1:0]      out_match_position
);

`include "substring_search_engine_defines.svh"

  // configuration registers
  needle_t          needle_r;
  logic [LEN_W-1:0] pat_len_r;
  logic             fold_r;
  logic [POS_W-1:0] limit_r;

  // input stage
  logic             in_vld_r;
  logic [7:0]       byte_r;
  logic             last_r;

  // search state
  logic [7:0]       win_r   [MAX_PATTERN];
  logic [7:0]       win_nxt [MAX_PATTERN];
  logic [POS_W-1:0] cnt_r;
  logic [POS_W-1:0] cnt_nxt;
  logic             given_r;
  logic             given_nxt;

  // result stage
  logic             out_vld_r;
  logic             found_r;
  logic [POS_W-1:0] pos_r;

  logic             adv;
  logic             ends;
  logic [LEN_W-1:0] used_len;
  logic [POS_W-1:0] cnt_inc;
  logic             match;
  logic             hit;
  logic             res_v;
  logic             res_f;
  logic [POS_W-1:0] res_pos;
  logic             rearm;
  logic             shift;
  cmp_cfg_t         cmp_cfg;

  assign cfg_ready = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_r  <= '0;
      pat_len_r <= '0;
      fold_r    <= 1'b0;
      limit_r   <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LOW:    needle_r[7:0]  <= cfg_data;
        REG_PATTERN_HIGH:   needle_r[15:8] <= cfg_data;
        REG_PATTERN_LENGTH: pat_len_r      <= cfg_data[LEN_W-1:0];
        REG_CASE_FOLD:      fold_r         <= cfg_data[0];
        REG_SEARCH_LIMIT:   limit_r        <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // lengths beyond the window size are clamped
  assign used_len = (pat_len_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_r;

  // the compute stage moves when the result register is free or being drained
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_text_byte;
      last_r <= in_last_byte;
    end
  end

  // window after the current byte shifts in, newest at 0
  always_comb begin
    win_nxt[0] = byte_r;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  // saturating byte count including the current byte
  assign cnt_inc = (&cnt_r) ? cnt_r : cnt_r + POS_W'(1);

  assign cmp_cfg.needle   = needle_r;
  assign cmp_cfg.used_len = used_len;
  assign cmp_cfg.fold     = fold_r;

  sse_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .cfg   (cmp_cfg),
    .win   (win_nxt),
    .match (match)
  );

  assign ends = last_r || (byte_r == 8'd0);
  assign hit  = match && (cnt_inc >= POS_W'(used_len)) && (cnt_inc <= limit_r);

  // per-byte decision
  always_comb begin
    res_v     = 1'b0;
    res_f     = 1'b0;
    res_pos   = '0;
    rearm     = 1'b0;
    shift     = 1'b0;
    given_nxt = given_r;
    if (given_r) begin
      // result already out, skip to end of string
      rearm = ends;
    end else if (used_len == '0) begin
      // empty needle matches at the first byte
      res_v = 1'b1;
      res_f = 1'b1;
      if (ends) rearm = 1'b1;
      else given_nxt = 1'b1;
    end else if (byte_r == 8'd0) begin
      res_v = 1'b1;
      rearm = 1'b1;
    end else begin
      shift = 1'b1;
      if (hit) begin
        res_v   = 1'b1;
        res_f   = 1'b1;
        res_pos = cnt_inc - POS_W'(used_len);
        if (last_r) rearm = 1'b1;
        else given_nxt = 1'b1;
      end else if (last_r) begin
        res_v = 1'b1;
        rearm = 1'b1;
      end
    end
    cnt_nxt = shift ? cnt_inc : cnt_r;
    if (rearm) begin
      cnt_nxt   = '0;
      given_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      given_r <= 1'b0;
      for (int i = 0; i < MAX_PATTERN; i++) win_r[i] <= 8'd0;
    end else if (adv) begin
      cnt_r   <= cnt_nxt;
      given_r <= given_nxt;
      if (rearm) begin
        for (int i = 0; i < MAX_PATTERN; i++) win_r[i] <= 8'd0;
      end else if (shift) begin
        win_r <= win_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res_v;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_v) begin
      found_r <= res_f;
      pos_r   <= res_pos;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_found          = found_r;
  assign out_match_position = pos_r;

  // checks
  `SSE_ASSERT_NOW(a_notfound_pos_zero, out_vld_r && !found_r, pos_r == '0,
                  "not-found result with nonzero position")
  `SSE_ASSERT_NEXT(a_given_silent, adv && given_r, !out_vld_r,
                   "result produced after result already given")
  `SSE_ASSERT_NEXT(a_zero_rearms, adv && byte_r == 8'd0, cnt_r == '0 && !given_r,
                   "zero byte did not rearm the search")

endmodule

>>> test/tb_substring_search_engine.sv
// testbench of the substring search engine: directed and random haystacks vs a predictor
module tb_substring_search_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import sse_pkg::*;

  localparam int HALF_PERIOD = 6;     // 12 ns clock
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 4;    // two register stages plus margin
  localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
  localparam int IDLE_PCT = 7;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int CALM_PHASE = 5;      // phase run with no idling on either side

  typedef struct {
    logic [7:0] text;
    logic       last;
  } hay_item_t;

  typedef struct {
    logic             found;
    logic [POS_W-1:0] pos;
  } match_report_t;

  // dut ports, the inputs all known from time zero
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_text_byte = '0;
  logic                  in_last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_found;
  logic [POS_W-1:0]      out_match_position;

  substring_search_engine dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_text_byte       (in_text_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_match_position (out_match_position)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // haystack items waiting for the driver, and reports waiting for the monitor
  hay_item_t     haystack_q[$];
  match_report_t match_q[$];
  int            in_flight = 0;   // queued or on the in ports, not yet accepted
  logic          calm = 1'b0;     // suppresses random idling on both sides

  // shadow of the register file, reset values
  logic [63:0] sh_needle_lo = '0;
  logic [63:0] sh_needle_hi = '0;
  logic [4:0]  sh_len = '0;
  logic        sh_fold = 1'b0;
  logic [31:0] sh_limit = '1;

  // predictor state of the current string
  logic [7:0]  hay_window [NEEDLE_BYTES];
  logic [31:0] seen_bytes;
  logic        reported;

  // needle used by the stimulus generator for the current phase
  logic [7:0]  gen_needle [NEEDLE_BYTES];
  int          gen_len = 0;

  int errors = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int strings_made = 0;
  int stall_cycles = 0;

  hay_item_t     next_item;
  match_report_t got_rep;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (sh_fold && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) r = c | 8'h20;
    return r;
  endfunction

  // string ended: window, count and the reported flag go back to reset
  task automatic restart_string();
    for (int i = 0; i < NEEDLE_BYTES; i++) hay_window[i] = 8'h00;
    seen_bytes = '0;
    reported = 1'b0;
  endtask

  // one accepted haystack item, pushes the report it causes if any
  task automatic search_step(input logic [7:0] c, input logic last);
    logic          ends;
    logic          hit;
    int unsigned   len;
    logic [127:0]  needle;
    logic [7:0]    nb;
    match_report_t rep;
    ends = last || (c == 8'h00);
    len = (sh_len > NEEDLE_BYTES) ? NEEDLE_BYTES : sh_len;
    needle = {sh_needle_hi, sh_needle_lo};
    if (reported) begin
      // answer already given, only the end of the string matters
      if (ends) restart_string();
    end else if (len == 0) begin
      // empty needle matches at offset 0 on any first byte, zero byte too
      rep.found = 1'b1;
      rep.pos = '0;
      match_q.push_back(rep);
      if (ends) restart_string();
      else reported = 1'b1;
    end else if (c == 8'h00) begin
      // zero byte ends the string and is never searched
      rep.found = 1'b0;
      rep.pos = '0;
      match_q.push_back(rep);
      restart_string();
    end else begin
      for (int i = NEEDLE_BYTES - 1; i > 0; i--) hay_window[i] = hay_window[i-1];
      hay_window[0] = c;
      if (seen_bytes != '1) seen_bytes = seen_bytes + 1;
      hit = (seen_bytes >= len) && (seen_bytes <= sh_limit);
      // newest window byte lines up with the last needle byte
      for (int i = 0; i < len; i++) begin
        nb = needle[8*(len-1-i) +: 8];
        if (nb == 8'h00 || lower_ascii(hay_window[i]) != lower_ascii(nb)) hit = 1'b0;
      end
      if (hit) begin
        rep.found = 1'b1;
        rep.pos = seen_bytes - len;
        match_q.push_back(rep);
        if (last) restart_string();
        else reported = 1'b1;
      end else if (last) begin
        rep.found = 1'b0;
        rep.pos = '0;
        match_q.push_back(rep);
        restart_string();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] toggle_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) r = c ^ 8'h20;
    return r;
  endfunction

  // letter-heavy needle byte from a small alphabet, index mixes the case
  function automatic logic [7:0] toggle_case8(input int idx);
    logic [7:0] c;
    c = 8'h61 + 8'($urandom_range(3));
    if (((idx + $urandom_range(1)) & 1) != 0) c = toggle_case(c);
    return c;
  endfunction

  // nonzero haystack byte, biased toward needle bytes so partial matches are common
  function automatic logic [7:0] hay_char();
    logic [7:0] c;
    case ($urandom_range(3))
      0, 1: c = (gen_len > 0) ? gen_needle[$urandom_range(gen_len - 1)] : 8'h61;
      2: c = 8'h61 + 8'($urandom_range(3));
      default: c = 8'($urandom_range(1, 255));
    endcase
    if (c == 8'h00) c = 8'h62;
    if ($urandom_range(3) == 0) c = toggle_case(c);
    return c;
  endfunction

  task automatic push_item(input logic [7:0] text, input logic last);
    hay_item_t it;
    it.text = text;
    it.last = last;
    haystack_q.push_back(it);
    in_flight++;
  endtask

  // nothing queued, nothing outstanding, then let the pipeline empty
  task automatic wait_idle();
    do @(posedge clk); while (in_flight != 0 || match_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write over the cfg channel, shadow follows on the handshake
  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_PATTERN_LOW: sh_needle_lo = data;
      REG_PATTERN_HIGH: sh_needle_hi = data;
      REG_PATTERN_LENGTH: sh_len = data[4:0];
      REG_CASE_FOLD: sh_fold = data[0];
      REG_SEARCH_LIMIT: sh_limit = data[31:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [4:0] len, input logic fold,
                               input logic [31:0] limit);
    put_reg(REG_PATTERN_LOW, lo);
    put_reg(REG_PATTERN_HIGH, hi);
    put_reg(REG_PATTERN_LENGTH, {59'd0, len});
    put_reg(REG_CASE_FOLD, {63'd0, fold});
    put_reg(REG_SEARCH_LIMIT, {32'd0, limit});
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // driver: one haystack item per handshake, random gaps between items
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        search_step(in_text_byte, in_last_byte);
        items_accepted++;
        in_flight--;
      end
      // the port is free after this edge: load the next item or idle
      if (!in_valid || in_ready) begin
        if (haystack_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          next_item = haystack_q.pop_front();
          in_valid <= 1'b1;
          in_text_byte <= next_item.text;
          in_last_byte <= next_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each result item with the oldest report, stall at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_found) hits_seen++;
        if (match_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item: expected none, actual found %0b position %0d",
                   $time, out_found, out_match_position);
        end else begin
          got_rep = match_q.pop_front();
          if (out_found !== got_rep.found) begin
            errors++;
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, got_rep.found, out_found);
          end
          if (out_match_position !== got_rep.pos) begin
            errors++;
            $display("%0t: match_position mismatch: expected %0d, actual %0d",
                     $time, got_rep.pos, out_match_position);
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no handshake on any channel ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d reports still expected",
                 $time, stall_cycles, match_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, directed strings, then random phases with fresh settings
  // ---------------------------------------------------------------------------
  initial begin
    int          ph;
    int          n;
    int          k;
    int          cnt;
    logic [4:0]  len_w;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        fold;
    logic [31:0] limit;
    logic [7:0]  nb;

    restart_string();
    for (k = 0; k < NEEDLE_BYTES; k++) gen_needle[k] = 8'h61;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty needle answers found at 0 on the first byte,
    // a zero byte included; later bytes ignored until the string ends
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h41, 1'b0);
    push_item(8'h00, 1'b1);
    push_item(8'h80, 1'b1);
    wait_idle();

    // needle "aZ" with folding: match ends on the marked byte, then
    // a zero byte and a lone marked byte both give not found
    load_settings(64'h5A61, '1, 5'd2, 1'b1, '1);
    push_item(8'h71, 1'b0);
    push_item(8'h41, 1'b0);
    push_item(8'h7A, 1'b1);
    push_item(8'h61, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h51, 1'b1);
    wait_idle();

    // length above the maximum, limit zero: the string stays open here
    load_settings(64'h0807060504030201, 64'h100F0E0D0C0B0A09, 5'd31, 1'b0, 32'd0);
    push_item(8'h78, 1'b0);
    push_item(8'h79, 1'b0);
    wait_idle();

    // settings changed in the middle of that string: third byte hits at the limit
    load_settings(64'h79, 64'h0, 5'd1, 1'b0, 32'd3);
    push_item(8'h79, 1'b0);
    push_item(8'h62, 1'b1);
    wait_idle();

    // needle byte of zero in use can never match
    load_settings(64'h0, '1, 5'd1, 1'b1, 32'd0);
    push_item(8'h63, 1'b1);
    wait_idle();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      // fresh needle, folding and limit for this phase
      case ($urandom_range(19))
        0, 1: len_w = 5'd0;
        2, 3: len_w = 5'($urandom_range(17, 31));
        4, 5, 6, 7: len_w = 5'($urandom_range(9, 16));
        default: len_w = 5'($urandom_range(1, 8));
      endcase
      gen_len = (len_w > NEEDLE_BYTES) ? NEEDLE_BYTES : len_w;
      for (k = 0; k < NEEDLE_BYTES; k++) begin
        if ($urandom_range(3) == 0) gen_needle[k] = 8'($urandom_range(1, 255));
        else gen_needle[k] = toggle_case8(k);
      end
      if (gen_len > 0 && $urandom_range(6) == 0) gen_needle[$urandom_range(gen_len - 1)] = 8'h00;
      for (k = 0; k < 8; k++) begin
        lo[8*k +: 8] = gen_needle[k];
        hi[8*k +: 8] = gen_needle[k+8];
      end
      fold = 1'($urandom_range(1));
      case ($urandom_range(19))
        0, 1, 2, 3, 4: limit = '1;
        5, 6: limit = 32'd0;
        7, 8: limit = 32'd1;
        9, 10, 11, 12: limit = $urandom;
        default: limit = 32'($urandom_range(1, 40));
      endcase
      load_settings(lo, hi, len_w, fold, limit);
      calm = (ph == CALM_PHASE);

      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(4) == 0) begin
          // noise: any byte value, zero included, rare marks
          cnt = $urandom_range(1, 12);
          repeat (cnt) push_item(8'($urandom_range(255)), $urandom_range(9) == 0);
          n += cnt;
        end else begin
          // well-formed string: prefix, maybe the needle, suffix, terminator unless left open
          strings_made++;
          cnt = $urandom_range(0, 16);
          repeat (cnt) push_item(hay_char(), 1'b0);
          n += cnt;
          if (gen_len > 0 && $urandom_range(9) < 7) begin
            for (k = 0; k < gen_len; k++) begin
              nb = (gen_needle[k] == 8'h00) ? 8'h61 : gen_needle[k];
              if ($urandom_range(3) == 0) nb = toggle_case(nb);
              push_item(nb, 1'b0);
            end
            n += gen_len;
          end
          cnt = $urandom_range(0, 6);
          repeat (cnt) push_item(hay_char(), 1'b0);
          n += cnt;
          case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
              push_item(8'h00, 1'($urandom_range(1)));
              n++;
            end
            5, 6, 7, 8: begin
              push_item(hay_char(), 1'b1);
              n++;
            end
            default: ;  // left open, carries into the next phase
          endcase
        end
      end
      // sender holds off until every report of the phase has come back
      wait_idle();
      calm = 1'b0;
    end

    $display("run covered %0d haystack items (%0d built strings) over %0d setting phases",
             items_accepted, strings_made, RAND_PHASES + 5);
    $display("checked %0d result items, %0d of them found, %0d mismatches",
             results_seen, hits_seen, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
